// ----- rtl/core/sse_pkg.sv -----
// Shared types and constants for the SSE event stream parser.
// Standalone package; used by every module of the parser core.
`timescale 1ns / 1ps
`default_nettype none
package sse_pkg;

  localparam int LINE_MAX_DEF       = 8192;
  localparam int EVENT_NAME_MAX_DEF = 63;
  localparam int ID_MAX_DEF         = 127;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_FINISH = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] NAME_DATA  = "data";
  localparam logic [39:0] NAME_EVENT = "event";
  localparam logic [15:0] NAME_ID    = "id";
  localparam logic [39:0] NAME_RETRY = "retry";

  typedef enum logic [2:0] {
    K_DATA      = 3'd0,
    K_BREAK     = 3'd1,
    K_EVENT     = 3'd2,
    K_ID        = 3'd3,
    K_EVENT_END = 3'd4,
    K_ID_END    = 3'd5,
    K_DISPATCH  = 3'd6,
    K_TOO_LONG  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    F_NONE  = 3'd0,
    F_DATA  = 3'd1,
    F_EVENT = 3'd2,
    F_ID    = 3'd3,
    F_RETRY = 3'd4
  } field_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value_byte;
    logic [6:0]  position;
    logic [31:0] retry_value;
    logic        retry_present;
    logic        event_named;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  typedef struct packed {
    logic        pending_cr;
    phase_t      phase;
    logic        name_bad;
    logic [2:0]  name_len;
    field_t      field;
    logic        space_check;
    logic [6:0]  value_pos;
    logic        data_nonempty;
    logic        event_nonempty;
    logic [31:0] retry_accum;
    logic        retry_present;
    logic        retry_stop;
    logic        overflow;
  } pstate_t;

  function automatic logic [2:0] name_size(field_t f);
    logic [2:0] n;
    unique case (f)
      F_DATA:  n = 3'd4;
      F_EVENT: n = 3'd5;
      F_ID:    n = 3'd2;
      F_RETRY: n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_char(field_t f, logic [2:0] n);
    logic [7:0] c;
    unique case (f)
      F_DATA:  c = 8'(NAME_DATA >> (6'd24 - {n, 3'b000}));
      F_EVENT: c = 8'(NAME_EVENT >> (6'd32 - {n, 3'b000}));
      F_ID:    c = 8'(NAME_ID >> (6'd8 - {n, 3'b000}));
      F_RETRY: c = 8'(NAME_RETRY >> (6'd32 - {n, 3'b000}));
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sse_front.sv -----
// Front end: accepts items, frames lines, matches field names and builds results.
// Depends on sse_pkg; pushes up to two results per item into sse_queue.
`timescale 1ns / 1ps
`default_nettype none
module sse_front #(
  parameter int LINE_MAX       = sse_pkg::LINE_MAX_DEF,
  parameter int EVENT_NAME_MAX = sse_pkg::EVENT_NAME_MAX_DEF,
  parameter int ID_MAX         = sse_pkg::ID_MAX_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [1:0]     mode,
  input  wire logic [7:0]     byte_value,
  output sse_pkg::push_t      push
);

  localparam int LL_W = $clog2(LINE_MAX + 1);

  typedef struct packed {
    sse_pkg::pstate_t st;
    logic             v;
    sse_pkg::res_t    res;
  } step_t;

  function automatic sse_pkg::field_t resolve(sse_pkg::pstate_t s);
    sse_pkg::field_t f;
    if (s.name_bad || s.field == sse_pkg::F_NONE ||
        s.name_len != sse_pkg::name_size(s.field)) begin
      f = sse_pkg::F_NONE;
    end else begin
      f = s.field;
    end
    return f;
  endfunction

  function automatic sse_pkg::pstate_t advance(sse_pkg::pstate_t s, logic [7:0] b);
    sse_pkg::pstate_t r;
    r = s;
    if (!s.name_bad) begin
      if (s.name_len == 3'd0) begin
        if (b == sse_pkg::name_char(sse_pkg::F_DATA, 3'd0)) begin
          r.field = sse_pkg::F_DATA;
        end else if (b == sse_pkg::name_char(sse_pkg::F_EVENT, 3'd0)) begin
          r.field = sse_pkg::F_EVENT;
        end else if (b == sse_pkg::name_char(sse_pkg::F_ID, 3'd0)) begin
          r.field = sse_pkg::F_ID;
        end else if (b == sse_pkg::name_char(sse_pkg::F_RETRY, 3'd0)) begin
          r.field = sse_pkg::F_RETRY;
        end else begin
          r.field = sse_pkg::F_NONE;
        end
        if (r.field == sse_pkg::F_NONE) begin
          r.name_bad = 1'b1;
        end else begin
          r.name_len = 3'd1;
        end
      end else if (s.field == sse_pkg::F_NONE ||
                   s.name_len >= sse_pkg::name_size(s.field) ||
                   sse_pkg::name_char(s.field, s.name_len) != b) begin
        r.name_bad = 1'b1;
      end else begin
        r.name_len = s.name_len + 3'd1;
      end
    end
    return r;
  endfunction

  function automatic step_t content_byte(sse_pkg::pstate_t s, logic [7:0] b);
    step_t           r;
    sse_pkg::field_t f;
    logic [35:0]     prod;
    r.st  = s;
    r.v   = 1'b0;
    r.res = sse_pkg::res_t'(0);
    prod  = {1'b0, s.retry_accum, 3'b000} + {3'b000, s.retry_accum, 1'b0} +
            {32'd0, b[3:0]};
    if (s.phase == sse_pkg::PH_NAME) begin
      if (b == sse_pkg::CH_COLON) begin
        f = resolve(s);
        r.st.field = f;
        if (f == sse_pkg::F_NONE) begin
          r.st.phase = sse_pkg::PH_SKIP;
        end else begin
          r.st.phase       = sse_pkg::PH_VALUE;
          r.st.space_check = 1'b1;
          r.st.value_pos   = 7'd0;
          if (f == sse_pkg::F_DATA && s.data_nonempty) begin
            r.v              = 1'b1;
            r.res.kind       = sse_pkg::K_BREAK;
            r.res.value_byte = sse_pkg::CH_LF;
          end
          if (f == sse_pkg::F_RETRY) begin
            r.st.retry_accum   = 32'd0;
            r.st.retry_present = 1'b1;
            r.st.retry_stop    = 1'b0;
          end
        end
      end else begin
        r.st = advance(s, b);
      end
    end else if (s.phase == sse_pkg::PH_VALUE) begin
      r.st.space_check = 1'b0;
      if (!(s.space_check && b == sse_pkg::CH_SPACE)) begin
        unique case (s.field)
          sse_pkg::F_DATA: begin
            r.v                = 1'b1;
            r.res.kind         = sse_pkg::K_DATA;
            r.res.value_byte   = b;
            r.st.data_nonempty = 1'b1;
          end
          sse_pkg::F_EVENT: begin
            if (s.value_pos < 7'(EVENT_NAME_MAX)) begin
              r.v              = 1'b1;
              r.res.kind       = sse_pkg::K_EVENT;
              r.res.value_byte = b;
              r.res.position   = s.value_pos;
              r.st.value_pos   = s.value_pos + 7'd1;
            end
          end
          sse_pkg::F_ID: begin
            if (s.value_pos < 7'(ID_MAX)) begin
              r.v              = 1'b1;
              r.res.kind       = sse_pkg::K_ID;
              r.res.value_byte = b;
              r.res.position   = s.value_pos;
              r.st.value_pos   = s.value_pos + 7'd1;
            end
          end
          sse_pkg::F_RETRY: begin
            if (!s.retry_stop) begin
              if (b >= sse_pkg::CH_ZERO && b <= sse_pkg::CH_NINE) begin
                r.st.retry_accum = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod[31:0];
              end else begin
                r.st.retry_stop = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function automatic step_t dispatch(sse_pkg::pstate_t s);
    step_t r;
    r.st  = s;
    r.v   = 1'b1;
    r.res = sse_pkg::res_t'(0);
    r.res.kind          = sse_pkg::K_DISPATCH;
    r.res.retry_value   = s.retry_present ? s.retry_accum : 32'd0;
    r.res.retry_present = s.retry_present;
    r.res.event_named   = s.event_nonempty;
    r.st.event_nonempty = 1'b0;
    r.st.data_nonempty  = 1'b0;
    r.st.retry_present  = 1'b0;
    r.st.retry_stop     = 1'b0;
    return r;
  endfunction

  function automatic step_t line_end(sse_pkg::pstate_t s, logic blank);
    step_t           r;
    sse_pkg::field_t f;
    r.st  = s;
    r.v   = 1'b0;
    r.res = sse_pkg::res_t'(0);
    f     = resolve(s);
    if (blank) begin
      r = dispatch(s);
    end else if (s.phase == sse_pkg::PH_NAME) begin
      unique case (f)
        sse_pkg::F_DATA: begin
          if (s.data_nonempty) begin
            r.v              = 1'b1;
            r.res.kind       = sse_pkg::K_BREAK;
            r.res.value_byte = sse_pkg::CH_LF;
          end
        end
        sse_pkg::F_EVENT: begin
          r.v                 = 1'b1;
          r.res.kind          = sse_pkg::K_EVENT_END;
          r.st.event_nonempty = 1'b0;
        end
        sse_pkg::F_ID: begin
          r.v        = 1'b1;
          r.res.kind = sse_pkg::K_ID_END;
        end
        sse_pkg::F_RETRY: begin
          r.st.retry_accum   = 32'd0;
          r.st.retry_present = 1'b1;
          r.st.retry_stop    = 1'b0;
        end
        default: ;
      endcase
    end else if (s.phase == sse_pkg::PH_VALUE) begin
      if (s.field == sse_pkg::F_EVENT) begin
        r.v                 = 1'b1;
        r.res.kind          = sse_pkg::K_EVENT_END;
        r.res.position      = s.value_pos;
        r.st.event_nonempty = (s.value_pos != 7'd0);
      end else if (s.field == sse_pkg::F_ID) begin
        r.v            = 1'b1;
        r.res.kind     = sse_pkg::K_ID_END;
        r.res.position = s.value_pos;
      end
    end
    r.st.pending_cr  = 1'b0;
    r.st.phase       = sse_pkg::PH_NAME;
    r.st.name_bad    = 1'b0;
    r.st.name_len    = 3'd0;
    r.st.field       = sse_pkg::F_NONE;
    r.st.space_check = 1'b0;
    r.st.value_pos   = 7'd0;
    return r;
  endfunction

  sse_pkg::pstate_t st_r, st_nxt;
  logic [LL_W-1:0]  line_cnt_r, line_cnt_nxt;

  sse_pkg::pstate_t st_nopend, st_after_cr;
  step_t            cr_step, byte_step, end_step, fin_disp;
  logic             blank, line_nonempty;
  logic             v0, v1;
  sse_pkg::res_t    r0, r1;

  always_comb begin
    st_nopend            = st_r;
    st_nopend.pending_cr = 1'b0;
    cr_step              = content_byte(st_nopend, sse_pkg::CH_CR);
    st_after_cr          = st_r.pending_cr ? cr_step.st : st_nopend;
    byte_step            = content_byte(st_after_cr, byte_value);
    blank                = (line_cnt_r == LL_W'(st_r.pending_cr));
    line_nonempty        = (line_cnt_r != '0);
    end_step             = line_end(st_r, blank);
    fin_disp             = dispatch(line_nonempty ? end_step.st : st_r);
  end

  always_comb begin
    st_nxt       = st_r;
    line_cnt_nxt = line_cnt_r;
    v0           = 1'b0;
    v1           = 1'b0;
    r0           = sse_pkg::res_t'(0);
    r1           = sse_pkg::res_t'(0);
    if (accept) begin
      case (mode)
        sse_pkg::MODE_BYTE: begin
          if (st_r.overflow || line_cnt_r >= LL_W'(LINE_MAX)) begin
            st_nxt.overflow = 1'b1;
            v0              = 1'b1;
            r0.kind         = sse_pkg::K_TOO_LONG;
          end else if (byte_value == sse_pkg::CH_LF) begin
            st_nxt       = end_step.st;
            line_cnt_nxt = '0;
            v0           = end_step.v;
            r0           = end_step.res;
          end else begin
            v0           = st_r.pending_cr && cr_step.v;
            r0           = cr_step.res;
            line_cnt_nxt = line_cnt_r + LL_W'(1);
            if (byte_value == sse_pkg::CH_CR) begin
              st_nxt            = st_after_cr;
              st_nxt.pending_cr = 1'b1;
            end else begin
              st_nxt = byte_step.st;
              v1     = byte_step.v;
              r1     = byte_step.res;
            end
          end
        end
        sse_pkg::MODE_FINISH: begin
          v0 = line_nonempty && end_step.v;
          r0 = end_step.res;
          v1 = line_nonempty ? (end_step.st.data_nonempty || end_step.st.event_nonempty)
                             : (st_r.data_nonempty || st_r.event_nonempty);
          r1 = fin_disp.res;
          st_nxt       = sse_pkg::pstate_t'(0);
          line_cnt_nxt = '0;
        end
        sse_pkg::MODE_RESET: begin
          st_nxt       = sse_pkg::pstate_t'(0);
          line_cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    push = sse_pkg::push_t'(0);
    if (v0 && v1) begin
      push.count       = 2'd2;
      push.first       = r0;
      push.second      = r1;
      push.second.last = 1'b1;
    end else if (v0 || v1) begin
      push.count      = 2'd1;
      push.first      = v0 ? r0 : r1;
      push.first.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= sse_pkg::pstate_t'(0);
      line_cnt_r <= '0;
    end else begin
      st_r       <= st_nxt;
      line_cnt_r <= line_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sse_queue.sv -----
// Result queue between front and back: two writes and one read per cycle.
// Depends on sse_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none
module sse_queue #(
  parameter int DEPTH = sse_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sse_pkg::push_t push,
  output logic               has_room,
  input  wire logic          pop,
  output logic               head_valid,
  output sse_pkg::res_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  sse_pkg::res_t   mem [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign head_valid = (count_r != '0);
  assign head       = mem[rd_r];
  assign has_room   = (count_r <= CW'(DEPTH - 2));
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = do_pop ? inc(rd_r) : rd_r;
    count_nxt = count_r + CW'(push.count) - CW'(do_pop);
    if (push.count == 2'd1) begin
      wr_nxt = inc(wr_r);
    end else if (push.count == 2'd2) begin
      wr_nxt = inc(inc(wr_r));
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[inc(wr_r)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sse_back.sv -----
// Back end: output register that drains the result queue onto the out_ channel.
// Depends on sse_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none
module sse_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire sse_pkg::res_t head,
  output logic               pop,
  input  wire logic          out_ready,
  output logic               out_valid,
  output sse_pkg::res_t      out_res
);

  logic          valid_r, valid_nxt;
  sse_pkg::res_t res_r;

  assign pop       = head_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sse_event_stream_parser_core.sv -----
// Server-Sent Events stream parser core: one byte, end-of-stream or reset item per
// transfer; streams data, event and id bytes, field ends and dispatch records.
// Depends on sse_pkg, sse_front, sse_queue and sse_back.
//
// The parser takes one item per clock cycle while in_ready is high. Each item is
// classified and the parser state updated in the same cycle it is accepted,
// producing zero, one or two results that go into a small result queue
// (QUEUE_DEPTH entries); an output register drains it at one result per cycle
// while out_ready is high. in_ready is high while the queue has at least two
// free entries, so the input rate is set by the output port. An item's first
// result reaches out_valid through the queue and then the output register.
`timescale 1ns / 1ps
`default_nettype none
module sse_event_stream_parser_core #(
  parameter int LINE_MAX       = sse_pkg::LINE_MAX_DEF,
  parameter int EVENT_NAME_MAX = sse_pkg::EVENT_NAME_MAX_DEF,
  parameter int ID_MAX         = sse_pkg::ID_MAX_DEF,
  parameter int QUEUE_DEPTH    = sse_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_byte_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_value_byte,
  output logic [6:0]       out_position,
  output logic [31:0]      out_retry_value,
  output logic             out_retry_present,
  output logic             out_event_named,
  output logic             out_last
);

  sse_pkg::push_t push;
  sse_pkg::res_t  head, out_res;
  logic           has_room, head_valid, pop;

  assign in_ready = has_room;

  sse_front #(
    .LINE_MAX       (LINE_MAX),
    .EVENT_NAME_MAX (EVENT_NAME_MAX),
    .ID_MAX         (ID_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_valid && has_room),
    .mode       (in_mode),
    .byte_value (in_byte_value),
    .push       (push)
  );

  sse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .has_room   (has_room),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_value_byte    = out_res.value_byte;
  assign out_position      = out_res.position;
  assign out_retry_value   = out_res.retry_value;
  assign out_retry_present = out_res.retry_present;
  assign out_event_named   = out_res.event_named;
  assign out_last          = out_res.last;

endmodule
`default_nettype wire
